// File: hdl/pol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and constants of the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int MAX_RESULTS      = 32;

   typedef enum logic [2:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_END   = 3'd1,
      MODE_INS_POS   = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_END   = 3'd4,
      MODE_DEL_POS   = 3'd5,
      MODE_READ_ALL  = 3'd6,
      MODE_UNUSED    = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_DELETED  = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_INVALID  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

endpackage

// File: hdl/positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed 32-bit values held in one synchronous memory.
//
//   Channel  Direction  Ports                                   Transfer
//   req      in         mode, value, position                   valid & ready
//   rsp      out        value_res, status, last, length         valid & ready
//
// An error goes straight to the response. An insert at position p moves the
// elements from p on up one place and then writes the value; a delete moves
// the elements behind p down one place, each by a read and a write back. A
// read-out reads each element and then emits it. Reset empties the list.
// A stalled result holds its register; the engine waits until it is taken.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
   parameter int CAPACITY = pol_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value_res,
   output logic [2:0]         rsp_status,
   output logic               rsp_last,
   output logic [5:0]         rsp_length
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT, S_DEL_GET, S_DEL_RD, S_DEL_WR,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      lim_ff, lim_in;
   logic               rd_mode_ff, rd_mode_in;
   logic signed [31:0] val_ff, val_in;
   pol_pkg::status_type st_ff, st_in;

   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] out_value_ff, out_value_in;
   logic [2:0]         out_status_ff, out_status_in;
   logic               out_last_ff, out_last_in;
   logic [5:0]         out_length_ff, out_length_in;

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] rd_data_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_wa, mem_ra;
   logic signed [31:0] mem_wd;

   logic               out_free;
   logic [7:0]         cnt8, p8;
   logic [CW-1:0]      idx_next;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign cnt8      = 8'(cnt_ff);
   assign idx_next  = CW'(idx_ff) + CW'(1);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      lim_in        = lim_ff;
      rd_mode_in    = rd_mode_ff;
      val_in        = val_ff;
      st_in         = st_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_length_in = out_length_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wa        = idx_ff;
      mem_ra        = idx_ff;
      mem_wd        = rd_data_ff;
      p8            = 8'd0;
      case (state_ff)
         S_IDLE: begin
            rd_mode_in = 1'b0;
            if (req_valid) begin
               case (req_mode)
                  pol_pkg::MODE_INS_FRONT, pol_pkg::MODE_INS_END,
                  pol_pkg::MODE_INS_POS: begin
                     if (req_mode == pol_pkg::MODE_INS_FRONT) begin
                        p8 = 8'd0;
                     end else if (req_mode == pol_pkg::MODE_INS_END) begin
                        p8 = cnt8;
                     end else begin
                        p8 = 8'(req_position);
                     end
                     val_in = req_value;
                     if (cnt8 >= 8'(CAPACITY)) begin
                        st_in    = pol_pkg::ST_FULL;
                        state_in = S_EMIT;
                     end else if (p8 > cnt8) begin
                        st_in    = pol_pkg::ST_INVALID;
                        state_in = S_EMIT;
                     end else begin
                        pos_in = AW'(p8);
                        if (p8 == cnt8) begin
                           state_in = S_INS_PUT;
                        end else begin
                           idx_in   = AW'(cnt8 - 8'd1);
                           state_in = S_INS_RD;
                        end
                     end
                  end
                  pol_pkg::MODE_DEL_FRONT, pol_pkg::MODE_DEL_END,
                  pol_pkg::MODE_DEL_POS: begin
                     if (req_mode == pol_pkg::MODE_DEL_FRONT) begin
                        p8 = 8'd0;
                     end else if (req_mode == pol_pkg::MODE_DEL_END) begin
                        p8 = cnt8 - 8'd1;
                     end else begin
                        p8 = 8'(req_position);
                     end
                     val_in = '0;
                     if (cnt8 == 8'd0) begin
                        st_in    = pol_pkg::ST_EMPTY;
                        state_in = S_EMIT;
                     end else if (p8 >= cnt8) begin
                        st_in    = pol_pkg::ST_INVALID;
                        state_in = S_EMIT;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = AW'(p8);
                        idx_in   = AW'(p8);
                        state_in = S_DEL_GET;
                     end
                  end
                  pol_pkg::MODE_READ_ALL: begin
                     val_in = '0;
                     if (cnt8 == 8'd0) begin
                        st_in    = pol_pkg::ST_EMPTY;
                        state_in = S_EMIT;
                     end else begin
                        rd_mode_in = 1'b1;
                        lim_in     = (cnt8 > 8'(pol_pkg::MAX_RESULTS)) ?
                                     CW'(pol_pkg::MAX_RESULTS) : cnt_ff;
                        idx_in     = '0;
                        state_in   = S_DEL_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            mem_re   = 1'b1;
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            mem_we = 1'b1;
            mem_wa = AW'(idx_next);
            if (idx_ff == pos_ff) begin
               state_in = S_INS_PUT;
            end else begin
               idx_in   = idx_ff - AW'(1);
               state_in = S_INS_RD;
            end
         end
         S_INS_PUT: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = val_ff;
            cnt_in   = cnt_ff + CW'(1);
            st_in    = pol_pkg::ST_INSERTED;
            state_in = S_EMIT;
         end
         S_DEL_GET: begin
            val_in = rd_data_ff;
            st_in  = pol_pkg::ST_DELETED;
            if (idx_next == cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_EMIT;
            end else begin
               idx_in   = AW'(idx_next);
               state_in = S_DEL_RD;
            end
         end
         S_DEL_RD: begin
            mem_re   = 1'b1;
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            if (rd_mode_ff) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_value_in  = rd_data_ff;
                  out_status_in = pol_pkg::ST_DELETED;
                  out_last_in   = (idx_next == lim_ff);
                  out_length_in = 6'(cnt_ff);
                  if (idx_next == lim_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = AW'(idx_next);
                     state_in = S_DEL_RD;
                  end
               end
            end else begin
               mem_we = 1'b1;
               mem_wa = idx_ff - AW'(1);
               if (idx_next == cnt_ff) begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = S_EMIT;
               end else begin
                  idx_in   = AW'(idx_next);
                  state_in = S_DEL_RD;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_value_in  = val_ff;
               out_status_in = st_ff;
               out_last_in   = 1'b1;
               out_length_in = 6'(cnt_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         rd_mode_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         rd_mode_ff   <= rd_mode_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      lim_ff        <= lim_in;
      val_ff        <= val_in;
      st_ff         <= st_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_length_ff <= out_length_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_res = out_value_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_length    = out_length_ff;

endmodule

// File: hdl/pol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_checker
// Port-level checks of the positional ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module pol_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_mode,
   input logic signed [31:0] req_value,
   input logic [5:0]         req_position,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value_res,
   input logic [2:0]         rsp_status,
   input logic               rsp_last,
   input logic [5:0]         rsp_length
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pol_pkg::ST_EMPTY) |->
      (rsp_length == 6'd0 && rsp_last && rsp_value_res == 32'sd0))
      else $error("Empty status with a nonempty list.");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == pol_pkg::ST_INVALID ||
                     rsp_status == pol_pkg::ST_FULL ||
                     rsp_status == pol_pkg::ST_INSERTED)) |-> rsp_last)
      else $error("Single-result command without last.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value_res)))
      else $error("Stalled result changed.");

   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode != pol_pkg::MODE_UNUSED) |=> !req_ready)
      else $error("Second transfer taken while a command is in progress.");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

// File: tb/positional_ordered_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_tb
// Drives list commands through the request channel, mirrors the list in a
// local queue to predict every response, and checks each response transfer
// field by field against the oldest predicted one, with random idling.
// ----------------------------------------------------------------------------
module positional_ordered_list_tb;

   localparam int CAP   = pol_pkg::CAPACITY_DEFAULT;
   localparam int LIMIT = 2000000;

   typedef struct {
      pol_pkg::mode_type  mode;
      logic signed [31:0] value;
      logic [5:0]         position;
   } command_type;

   typedef struct {
      logic signed [31:0]  value_res;
      pol_pkg::status_type status;
      logic                last;
      logic [5:0]          length;
   } response_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_mode;
   logic signed [31:0] req_value;
   logic [5:0]         req_position;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_value_res;
   logic [2:0]         rsp_status;
   logic               rsp_last;
   logic [5:0]         rsp_length;

   command_type        pending_cmds[$];
   response_type       expected_rsps[$];
   logic signed [31:0] list_model[$];
   int                 failures;
   int                 cycle_count;
   int                 send_gap;
   int                 recv_gap;
   int                 hold_off;
   bit                 quiet;

   positional_ordered_list u_top (
      clock, reset, req_valid, req_ready, req_mode, req_value, req_position,
      rsp_valid, rsp_ready, rsp_value_res, rsp_status, rsp_last, rsp_length
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void push_rsp(logic signed [31:0] v, pol_pkg::status_type st,
                                    logic lst);
      response_type r;
      r.value_res = v;
      r.status    = st;
      r.last      = lst;
      r.length    = 6'(list_model.size());
      expected_rsps.push_back(r);
   endfunction

   // Updates the list mirror and queues the responses one command causes.
   function automatic void predict_list(command_type c);
      int n;
      int p;
      n = list_model.size();
      case (c.mode)
         pol_pkg::MODE_INS_FRONT, pol_pkg::MODE_INS_END, pol_pkg::MODE_INS_POS: begin
            p = (c.mode == pol_pkg::MODE_INS_FRONT) ? 0 :
                (c.mode == pol_pkg::MODE_INS_END) ? n : int'(c.position);
            if (n >= CAP) push_rsp(c.value, pol_pkg::ST_FULL, 1'b1);
            else if (p > n) push_rsp(c.value, pol_pkg::ST_INVALID, 1'b1);
            else begin
               list_model.insert(p, c.value);
               push_rsp(c.value, pol_pkg::ST_INSERTED, 1'b1);
            end
         end
         pol_pkg::MODE_DEL_FRONT, pol_pkg::MODE_DEL_END, pol_pkg::MODE_DEL_POS: begin
            p = (c.mode == pol_pkg::MODE_DEL_FRONT) ? 0 :
                (c.mode == pol_pkg::MODE_DEL_END) ? n - 1 : int'(c.position);
            if (n == 0) push_rsp(0, pol_pkg::ST_EMPTY, 1'b1);
            else if (p >= n) push_rsp(0, pol_pkg::ST_INVALID, 1'b1);
            else begin
               logic signed [31:0] v;
               v = list_model[p];
               list_model.delete(p);
               push_rsp(v, pol_pkg::ST_DELETED, 1'b1);
            end
         end
         pol_pkg::MODE_READ_ALL: begin
            if (n == 0) push_rsp(0, pol_pkg::ST_EMPTY, 1'b1);
            else for (int i = 0; i < n && i < pol_pkg::MAX_RESULTS; i++)
               push_rsp(list_model[i], pol_pkg::ST_DELETED,
                        (i + 1 == n || i + 1 == pol_pkg::MAX_RESULTS));
         end
         default: ;
      endcase
   endfunction

   function automatic command_type make_cmd(pol_pkg::mode_type m, logic signed [31:0] v,
                                            logic [5:0] p);
      command_type c;
      c.mode     = m;
      c.value    = v;
      c.position = p;
      return c;
   endfunction

   function automatic command_type random_cmd(int fill_bias);
      int                r;
      pol_pkg::mode_type m;
      r = $urandom_range(0, 99);
      if (r < fill_bias) m = pol_pkg::mode_type'($urandom_range(0, 2));
      else if (r < 85) m = pol_pkg::mode_type'($urandom_range(3, 5));
      else if (r < 97) m = pol_pkg::MODE_READ_ALL;
      else m = pol_pkg::MODE_UNUSED;
      return make_cmd(m, $urandom, ($urandom_range(0, 9) == 0) ? 6'($urandom) :
                      6'($urandom_range(0, 33)));
   endfunction

   // Driver: one command per transfer, random bursts of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) predict_list(pending_cmds.pop_front());
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds.size() == 1 && quiet &&
                        expected_rsps.size() > 0)) begin
            req_valid    <= 1'b1;
            req_mode     <= pending_cmds[0].mode;
            req_value    <= pending_cmds[0].value;
            req_position <= pending_cmds[0].position;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver idling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response value=%0d status=%0d", $time,
                        rsp_value_res, rsp_status);
               failures++;
            end else begin
               response_type e;
               e = expected_rsps.pop_front();
               if (rsp_value_res !== e.value_res || rsp_status !== e.status ||
                   rsp_last !== e.last || rsp_length !== e.length) begin
                  $display({"%0t: mismatch expected v=%0d st=%0d last=%0b len=%0d,",
                            " actual v=%0d st=%0d last=%0b len=%0d"},
                           $time, e.value_res, e.status, e.last, e.length,
                           rsp_value_res, rsp_status, rsp_last, rsp_length);
                  failures++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 15);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("positional_ordered_list verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      failures     = 0;
      cycle_count  = 0;
      hold_off     = 0;
      quiet        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = pol_pkg::MODE_INS_FRONT;
      req_value    = 0;
      req_position = 0;
      rsp_ready    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list cases, extremes, every mode, invalid positions.
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_READ_ALL, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_FRONT, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_END, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_POS, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_POS, 5, 1));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_FRONT, 32'sh7fffffff, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_FRONT, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_END, 32'sh80000000, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_POS, -1, 1));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_POS, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_POS, 7, 63));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_POS, 0, 3));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_POS, 0, 63));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_UNUSED, -1, 63));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_READ_ALL, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_POS, 0, 1));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_END, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_END, 0, 0));
      // Fill to capacity, overflow, then read the full list.
      for (int i = 0; i < 33; i++)
         pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_END, $urandom, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_POS, 1, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_READ_ALL, 0, 0));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_DEL_POS, 0, 31));
      pending_cmds.push_back(make_cmd(pol_pkg::MODE_INS_POS, 2, 31));
      wait_drained();

      // The receiver stalls for a long stretch while commands keep coming.
      for (int i = 0; i < 20; i++) pending_cmds.push_back(random_cmd(50));
      hold_off = 400;
      wait_drained();

      // Random phases sweeping the list between empty and full.
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 42; i++)
            pending_cmds.push_back(random_cmd((ph % 2 == 0) ? 75 : 25));
         wait_drained();
      end

      quiet = 1'b1;
      for (int i = 0; i < 30; i++) pending_cmds.push_back(random_cmd(55));
      wait_drained();
      repeat (100) @(posedge clock);
      if (expected_rsps.size() != 0) failures++;
      if (failures == 0) begin
         $display("positional_ordered_list verification clean");
      end else begin
         $display("positional_ordered_list verification failed");
      end
      $finish;
   end

endmodule
